@@ src/vox_los_pkg.sv @@
// ----------------------------------------------------------------------------
// vox_los_pkg: shared types and constants for the voxel line-of-sight block
// Grid size, coordinate and error widths, item kinds and the job record
// passed from the classifier to the walk engine.
// ----------------------------------------------------------------------------
package vox_los_pkg;

  // grid extent; coordinates are fixed at CRD_W bits by the item format
  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;

  localparam int CRD_W  = 6;
  localparam int ROW_W  = 2 ** CRD_W;     // one row holds every x of a (z, y)
  localparam int ROW_AW = 2 * CRD_W;      // row address is {z, y}
  localparam int ROWS   = 2 ** ROW_AW;
  localparam int ERR_W  = CRD_W + 4;      // signed Bresenham error term
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic [CRD_W-1:0]  crd_t;
  typedef logic [ROW_AW-1:0] row_addr_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // classified item
  typedef struct packed {
    kind_t      kind;
    crd_t       src_x;
    crd_t       src_y;
    crd_t       src_z;
    logic [2:0] neg;      // per axis {z, y, x}: walk toward lower coordinate
    axis_t      major;
    crd_t       len_maj;
    crd_t       len_b;    // first minor axis, (major + 1) mod 3
    crd_t       len_c;    // second minor axis, (major + 2) mod 3
  } job_t;

  function automatic logic in_grid(crd_t x, crd_t y, crd_t z);
    return (int'(x) < GRID_X) && (int'(y) < GRID_Y) && (int'(z) < GRID_Z);
  endfunction

endpackage

@@ src/vox_los_ifs.sv @@
// ----------------------------------------------------------------------------
// vox_los channel interfaces
// Valid/ready channels for items in and results out.
// ----------------------------------------------------------------------------
interface vox_los_in_if import vox_los_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  crd_t       src_x;
  crd_t       src_y;
  crd_t       src_z;
  crd_t       dst_x;
  crd_t       dst_y;
  crd_t       dst_z;

  modport source (output valid, kind, src_x, src_y, src_z, dst_x, dst_y, dst_z,
                  input ready);
  modport sink   (input valid, kind, src_x, src_y, src_z, dst_x, dst_y, dst_z,
                  output ready);
endinterface

interface vox_los_out_if import vox_los_pkg::*; ();
  logic valid;
  logic ready;
  logic blocked;

  modport source (output valid, blocked, input ready);
  modport sink   (input valid, blocked, output ready);
endinterface

@@ src/voxel_occupancy_line_of_sight.sv @@
// ----------------------------------------------------------------------------
// voxel_occupancy_line_of_sight: voxel map with 3D Bresenham line of sight
// Top level: classifier, job queue and walk engine with the occupancy map.
// ----------------------------------------------------------------------------
// The block keeps one occupancy bit per voxel of a 64x64x64 grid, stored as
// 4096 rows of 64 bits addressed by {z, y}. Each accepted item gives exactly
// one result transfer; blocked is 1 only for a line query that met an
// occupied voxel, the endpoint included, and voxels outside the grid read as
// free and ignore marks. Items are run one at a time in the walk engine while
// the classifier and a two-deep job queue keep taking new items. A line query
// reads one voxel per cycle from the single read port, L + 1 reads in all, where
// L is the largest absolute coordinate delta. A mark reads the row, modifies
// the bit and writes the row back. A clear-all writes one row per cycle. After
// reset the map is cleared by the same row sweep, and no item is accepted until
// it is done. A finished result waits in an output register, so the engine
// starts the next job while the previous result is not yet taken, and stalls
// only when a second result is ready before the first has gone out.
// ----------------------------------------------------------------------------
module voxel_occupancy_line_of_sight import vox_los_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  vox_los_in_if.sink    in_ch,
  vox_los_out_if.source out_ch
);

  logic q_push, q_ready, q_pop, q_valid, init_busy;
  job_t push_job, head_job;

  // classify each item as it is transferred in
  vox_los_front u_front (
    .in_ch     (in_ch),
    .init_busy (init_busy),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // decouple intake from the walk engine
  vox_los_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (head_job)
  );

  // run marks, clears and queries against the map; hold the result register
  vox_los_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

@@ src/vox_los_front.sv @@
// ----------------------------------------------------------------------------
// vox_los_front: item classifier
// Works out per-axis direction and length and the dominant axis of a query.
// ----------------------------------------------------------------------------
module vox_los_front import vox_los_pkg::*; (
  vox_los_in_if.sink in_ch,
  input  logic       init_busy,
  input  logic       q_ready,
  output logic       q_push,
  output job_t       q_job
);

  logic neg_x, neg_y, neg_z;
  crd_t len_x, len_y, len_z;

  always_comb begin
    neg_x = in_ch.dst_x < in_ch.src_x;
    neg_y = in_ch.dst_y < in_ch.src_y;
    neg_z = in_ch.dst_z < in_ch.src_z;
    len_x = neg_x ? in_ch.src_x - in_ch.dst_x : in_ch.dst_x - in_ch.src_x;
    len_y = neg_y ? in_ch.src_y - in_ch.dst_y : in_ch.dst_y - in_ch.src_y;
    len_z = neg_z ? in_ch.src_z - in_ch.dst_z : in_ch.dst_z - in_ch.src_z;

    q_job.kind  = kind_t'(in_ch.kind);
    q_job.src_x = in_ch.src_x;
    q_job.src_y = in_ch.src_y;
    q_job.src_z = in_ch.src_z;
    q_job.neg   = {neg_z, neg_y, neg_x};

    // ties go to x, then y
    if (len_x >= len_y && len_x >= len_z) begin
      q_job.major   = AX_X;
      q_job.len_maj = len_x;
      q_job.len_b   = len_y;
      q_job.len_c   = len_z;
    end else if (len_y >= len_z) begin
      q_job.major   = AX_Y;
      q_job.len_maj = len_y;
      q_job.len_b   = len_z;
      q_job.len_c   = len_x;
    end else begin
      q_job.major   = AX_Z;
      q_job.len_maj = len_z;
      q_job.len_b   = len_x;
      q_job.len_c   = len_y;
    end
  end

  // hold off items while the map is being cleared after reset
  assign in_ch.ready = q_ready && !init_busy;
  assign q_push      = in_ch.valid && in_ch.ready;

endmodule

@@ src/vox_los_queue.sv @@
// ----------------------------------------------------------------------------
// vox_los_queue: job queue
// Short FIFO of classified jobs between the classifier and the walk engine.
// ----------------------------------------------------------------------------
module vox_los_queue import vox_los_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t           ent_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign push_ready = cnt_r != (QAW+1)'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

endmodule

@@ src/vox_los_back.sv @@
// ----------------------------------------------------------------------------
// vox_los_back: walk engine
// Owns the occupancy memory; runs marks, clears and Bresenham queries.
// ----------------------------------------------------------------------------
module vox_los_back import vox_los_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  job_t q_job,
  output logic q_pop,
  output logic init_busy,
  vox_los_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_WALK, ST_DRAIN, ST_MRD, ST_MWR, ST_CLR, ST_DONE
  } state_t;

  state_t     state_r, state_nxt;
  kind_t      kind_r, kind_nxt;
  crd_t       px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [2:0] neg_r, neg_nxt;
  axis_t      major_r, major_nxt;
  crd_t       len_maj_r, len_maj_nxt, len_b_r, len_b_nxt, len_c_r, len_c_nxt;
  crd_t       rem_r, rem_nxt;
  err_t       err_b_r, err_b_nxt, err_c_r, err_c_nxt;
  logic       hit_r, hit_nxt;
  row_addr_t  sweep_r, sweep_nxt;
  logic       res_valid_r, res_valid_nxt, res_blocked_r, res_blocked_nxt;

  row_t       mem [ROWS];
  row_t       rd_row_r;
  crd_t       rd_x_r;
  logic       rd_vld_r;
  logic       mem_we;
  row_addr_t  mem_wa, mem_ra;
  row_t       mem_wd;

  logic       sb, sc, step_x, step_y, step_z;
  err_t       two_maj, two_b, two_c, two_b_init, two_c_init;
  logic       cur_hit;

  assign init_busy     = state_r == ST_INIT;
  assign out_ch.valid  = res_valid_r;
  assign out_ch.blocked = res_blocked_r;

  assign cur_hit = rd_vld_r && rd_row_r[rd_x_r];

  always_comb begin
    two_maj    = err_t'({len_maj_r, 1'b0});
    two_b      = err_t'({len_b_r, 1'b0});
    two_c      = err_t'({len_c_r, 1'b0});
    two_b_init = err_t'({q_job.len_b, 1'b0});
    two_c_init = err_t'({q_job.len_c, 1'b0});
    sb = err_b_r > 0;
    sc = err_c_r > 0;
    case (major_r)
      AX_Y: begin
        step_y = 1'b1; step_z = sb; step_x = sc;
      end
      AX_Z: begin
        step_z = 1'b1; step_x = sb; step_y = sc;
      end
      default: begin
        step_x = 1'b1; step_y = sb; step_z = sc;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    pz_nxt          = pz_r;
    neg_nxt         = neg_r;
    major_nxt       = major_r;
    len_maj_nxt     = len_maj_r;
    len_b_nxt       = len_b_r;
    len_c_nxt       = len_c_r;
    rem_nxt         = rem_r;
    err_b_nxt       = err_b_r;
    err_c_nxt       = err_c_r;
    hit_nxt         = hit_r;
    sweep_nxt       = sweep_r;
    res_valid_nxt   = res_valid_r && !out_ch.ready;
    res_blocked_nxt = res_blocked_r;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = {pz_r, py_r};
    mem_ra          = {pz_r, py_r};
    mem_wd          = rd_row_r;
    mem_wd[px_r]    = kind_r == KIND_SET;

    case (state_r)
      ST_INIT, ST_CLR: begin
        mem_we    = 1'b1;
        mem_wa    = sweep_r;
        mem_wd    = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          kind_nxt    = q_job.kind;
          px_nxt      = q_job.src_x;
          py_nxt      = q_job.src_y;
          pz_nxt      = q_job.src_z;
          neg_nxt     = q_job.neg;
          major_nxt   = q_job.major;
          len_maj_nxt = q_job.len_maj;
          len_b_nxt   = q_job.len_b;
          len_c_nxt   = q_job.len_c;
          rem_nxt     = q_job.len_maj;
          err_b_nxt   = two_b_init - err_t'(q_job.len_maj);
          err_c_nxt   = two_c_init - err_t'(q_job.len_maj);
          hit_nxt     = 1'b0;
          sweep_nxt   = '0;
          case (q_job.kind)
            KIND_QUERY: state_nxt = ST_WALK;
            KIND_CLEAR: state_nxt = ST_CLR;
            default:    state_nxt = ST_MRD;
          endcase
        end
      end
      ST_WALK: begin
        // read the current voxel, fold in the one read last cycle
        hit_nxt = hit_r || cur_hit;
        if (rem_r == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          rem_nxt   = rem_r - 1'b1;
          px_nxt    = step_x ? (neg_r[0] ? px_r - 1'b1 : px_r + 1'b1) : px_r;
          py_nxt    = step_y ? (neg_r[1] ? py_r - 1'b1 : py_r + 1'b1) : py_r;
          pz_nxt    = step_z ? (neg_r[2] ? pz_r - 1'b1 : pz_r + 1'b1) : pz_r;
          err_b_nxt = (sb ? err_b_r - two_maj : err_b_r) + two_b;
          err_c_nxt = (sc ? err_c_r - two_maj : err_c_r) + two_c;
        end
      end
      ST_DRAIN: begin
        hit_nxt   = hit_r || cur_hit;
        state_nxt = ST_DONE;
      end
      ST_MRD: begin
        state_nxt = ST_MWR;
      end
      ST_MWR: begin
        // drop marks outside the grid
        mem_we    = in_grid(px_r, py_r, pz_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid_r || out_ch.ready) begin
          res_valid_nxt   = 1'b1;
          res_blocked_nxt = hit_r && kind_r == KIND_QUERY;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      res_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      res_valid_r <= res_valid_nxt;
      rd_vld_r    <= state_r == ST_WALK && in_grid(px_r, py_r, pz_r);
    end
    kind_r        <= kind_nxt;
    px_r          <= px_nxt;
    py_r          <= py_nxt;
    pz_r          <= pz_nxt;
    neg_r         <= neg_nxt;
    major_r       <= major_nxt;
    len_maj_r     <= len_maj_nxt;
    len_b_r       <= len_b_nxt;
    len_c_r       <= len_c_nxt;
    rem_r         <= rem_nxt;
    err_b_r       <= err_b_nxt;
    err_c_r       <= err_c_nxt;
    hit_r         <= hit_nxt;
    res_blocked_r <= res_blocked_nxt;
    rd_x_r        <= px_r;
  end

  // occupancy rows: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_row_r <= mem[mem_ra];
  end

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && q_valid))
    else $error("job popped outside idle");

  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && rem_r != '0) |=>
      (state_r == ST_WALK && rem_r == $past(rem_r) - 1'b1))
    else $error("walk counter skipped");

  a_write_when: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_INIT || state_r == ST_CLR || state_r == ST_MWR))
    else $error("map written outside a mark or clear");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> res_valid_r)
    else $error("result not presented");

endmodule
